/* rtl/brts_pkg.sv */
// ----------------------------------------------------------------------------
// brts_pkg
// Shared types and codes of the BLE response timeout supervisor.
// ----------------------------------------------------------------------------
package brts_pkg;

    localparam int unsigned KindCount = 20;

    // message kinds
    localparam logic [4:0] K_OTHER          = 5'd0;
    localparam logic [4:0] K_BUSY           = 5'd1;
    localparam logic [4:0] K_ERROR          = 5'd2;
    localparam logic [4:0] K_INIT_ACCESS    = 5'd3;
    localparam logic [4:0] K_INIT_RKE       = 5'd4;
    localparam logic [4:0] K_AP_REQ         = 5'd5;
    localparam logic [4:0] K_AP_RSP         = 5'd6;
    localparam logic [4:0] K_ACCESS_DONE    = 5'd7;
    localparam logic [4:0] K_INIT_RANGING   = 5'd8;
    localparam logic [4:0] K_RESUME_RANGING = 5'd9;
    localparam logic [4:0] K_SETUP_M1       = 5'd10;
    localparam logic [4:0] K_SETUP_M2       = 5'd11;
    localparam logic [4:0] K_SETUP_M3       = 5'd12;
    localparam logic [4:0] K_SETUP_M4       = 5'd13;
    localparam logic [4:0] K_SETUP_LATER    = 5'd14;
    localparam logic [4:0] K_RESUME_LATER   = 5'd15;
    localparam logic [4:0] K_SUSPEND_REQ    = 5'd16;
    localparam logic [4:0] K_SUSPEND_RSP    = 5'd17;
    localparam logic [4:0] K_RESUME_REQ     = 5'd18;
    localparam logic [4:0] K_RESUME_RSP     = 5'd19;
    localparam logic [4:0] K_LAST           = 5'd19;

    // roles
    localparam logic [1:0] ROLE_IDLE   = 2'd0;
    localparam logic [1:0] ROLE_TX     = 2'd1;
    localparam logic [1:0] ROLE_RX     = 2'd2;
    localparam logic [1:0] ROLE_UNUSED = 2'd3;

    // actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_ARM  = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;
    localparam logic [1:0] ACT_TERM = 2'd3;

    localparam logic DIR_IN  = 1'b0;
    localparam logic DIR_OUT = 1'b1;

    // kinds that wait for a response under a timeout
    localparam logic [KindCount-1:0] ExpectsReplyMask =
        (KindCount'(1) << K_INIT_ACCESS)  | (KindCount'(1) << K_INIT_RKE)     |
        (KindCount'(1) << K_AP_REQ)       | (KindCount'(1) << K_AP_RSP)       |
        (KindCount'(1) << K_INIT_RANGING) | (KindCount'(1) << K_RESUME_RANGING) |
        (KindCount'(1) << K_SETUP_M1)     | (KindCount'(1) << K_SETUP_M2)     |
        (KindCount'(1) << K_SETUP_M3)     | (KindCount'(1) << K_SUSPEND_REQ)  |
        (KindCount'(1) << K_RESUME_REQ);

    typedef struct packed {
        logic       direction;
        logic [4:0] message_kind;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] role_after;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] role;
        logic [4:0] pending;
    } t_sup_state;

    // set of kinds accepted as reply to a pending kind
    function automatic logic [KindCount-1:0] reply_mask(input logic [4:0] pend);
        logic [KindCount-1:0] m;
        m = '0;
        unique case (pend)
            K_INIT_ACCESS:    m[K_AP_REQ] = 1'b1;
            K_INIT_RKE:       m[K_AP_REQ] = 1'b1;
            K_AP_REQ:         m[K_AP_RSP] = 1'b1;
            K_AP_RSP: begin
                m[K_AP_REQ]      = 1'b1;
                m[K_ACCESS_DONE] = 1'b1;
            end
            K_INIT_RANGING: begin
                m[K_SETUP_M1]    = 1'b1;
                m[K_SETUP_LATER] = 1'b1;
            end
            K_RESUME_RANGING: begin
                m[K_RESUME_REQ]   = 1'b1;
                m[K_RESUME_LATER] = 1'b1;
            end
            K_SETUP_M1: begin
                m[K_SETUP_M2]    = 1'b1;
                m[K_SETUP_LATER] = 1'b1;
            end
            K_SETUP_M2:       m[K_SETUP_M3] = 1'b1;
            K_SETUP_M3:       m[K_SETUP_M4] = 1'b1;
            K_SUSPEND_REQ:    m[K_SUSPEND_RSP] = 1'b1;
            K_RESUME_REQ: begin
                m[K_RESUME_RSP]   = 1'b1;
                m[K_RESUME_LATER] = 1'b1;
            end
            default:          m = '0;
        endcase
        return m;
    endfunction

endpackage

/* rtl/brts_decide.sv */
// ----------------------------------------------------------------------------
// brts_decide
// Decision logic: one message and the current state give an action and the
// next state.
// ----------------------------------------------------------------------------
module brts_decide (
    input  brts_pkg::t_in_beat   i_beat,
    input  brts_pkg::t_sup_state i_state,
    output logic [1:0]           o_action,
    output brts_pkg::t_sup_state o_state
);
    import brts_pkg::*;

    logic [4:0]           kind;
    logic                 against;
    logic                 tx_in;
    logic                 rx_out;
    logic                 expects;
    logic                 reply_ok;
    logic                 replaces;
    logic [KindCount-1:0] allowed;
    t_sup_state           made;

    always_comb begin
        // fold unlisted codes onto "other"
        kind     = (i_beat.message_kind > K_LAST) ? K_OTHER : i_beat.message_kind;
        tx_in    = (i_beat.direction == DIR_IN)  && (i_state.role == ROLE_TX);
        rx_out   = (i_beat.direction == DIR_OUT) && (i_state.role == ROLE_RX);
        against  = tx_in || rx_out;
        expects  = ExpectsReplyMask[kind];
        allowed  = reply_mask(i_state.pending);
        reply_ok = allowed[kind];
        replaces = ((i_state.pending == K_RESUME_REQ) || (i_state.pending == K_SUSPEND_REQ))
                && ((kind == K_INIT_RANGING) || (kind == K_RESUME_RANGING)
                    || (kind == K_SUSPEND_REQ));
        made.role    = (i_beat.direction == DIR_OUT) ? ROLE_TX : ROLE_RX;
        made.pending = kind;

        o_action = ACT_NONE;
        o_state  = i_state;
        if (kind == K_BUSY) begin
            o_action = against ? ACT_ARM : ACT_NONE;
        end else if (kind == K_ERROR) begin
            if (tx_in) begin
                o_action = ACT_TERM;
                o_state  = '{role: ROLE_IDLE, pending: K_OTHER};
            end else if (rx_out) begin
                o_action = ACT_STOP;
                o_state  = '{role: ROLE_IDLE, pending: K_OTHER};
            end
        end else if (i_state.role != ROLE_IDLE) begin
            if (against && reply_ok) begin
                if (expects) begin
                    o_action = ACT_ARM;
                    o_state  = made;
                end else begin
                    o_action = ACT_STOP;
                    o_state  = '{role: ROLE_IDLE, pending: K_OTHER};
                end
            end else if (tx_in && replaces) begin
                // incoming request wins the collision
                o_action = ACT_ARM;
                o_state  = made;
            end
        end else if (expects) begin
            o_action = ACT_ARM;
            o_state  = made;
        end
    end

endmodule

/* rtl/ble_response_timeout_supervisor_core.sv */
// ----------------------------------------------------------------------------
// ble_response_timeout_supervisor_core
// Path: input register, then decision into the result register together with the
//   state update.
// Throughput: one message per cycle; the only limit is the downstream stall.
// Reset: synchronous, active low; role returns to idle, no pending message,
//   both pipeline stages empty.
// ----------------------------------------------------------------------------
module ble_response_timeout_supervisor_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  brts_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output brts_pkg::t_out_beat o_out_data
);
    import brts_pkg::*;

    // input stage
    logic       r_in_valid;
    t_in_beat   r_in_beat;
    // result stage
    logic       r_out_valid;
    t_out_beat  r_out_beat;
    // supervisor state
    t_sup_state r_state;
    t_sup_state n_state;
    logic [1:0] n_action;

    logic out_adv;  // result register may load
    logic in_adv;   // input register may load
    logic fire;     // a message is decided this cycle

    // The result register frees up when empty or when its beat leaves.
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign in_adv     = !r_in_valid || out_adv;
    assign fire       = r_in_valid && out_adv;
    assign o_in_stall = !in_adv;

    brts_decide u_decide (
        .i_beat   (r_in_beat),
        .i_state  (r_state),
        .o_action (n_action),
        .o_state  (n_state)
    );

    // Hold the input beat until the decision stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in_beat <= i_in_data;
        end
    end

    // Advance the state only when a decision is committed to the result stage,
    // so the next message in the input register always sees the updated state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{role: ROLE_IDLE, pending: K_OTHER};
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_beat.action     <= n_action;
            r_out_beat.role_after <= n_state.role;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

    // The unused role code never shows up.
    a_role_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.role != ROLE_UNUSED)
        else $error("supervisor role took the unused code");

    // Idle role and empty pending slot always go together.
    a_idle_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.role == ROLE_IDLE) == (r_state.pending == K_OTHER))
        else $error("role and pending kind disagree");

    // A terminate leaves the exchange idle; an arm never does.
    a_term_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.action == ACT_TERM) |-> r_out_beat.role_after == ROLE_IDLE)
        else $error("terminate without returning to idle");

    a_arm_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.action == ACT_ARM) |-> r_out_beat.role_after != ROLE_IDLE)
        else $error("timeout armed while idle");

    // A decided beat carries the state that was committed with it.
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out_valid && r_out_beat.role_after == r_state.role))
        else $error("result role differs from committed state");

endmodule
